// File: rtl/core/fiber_log_strain_stress_defines.svh
// ----------------------------------------------------------------------------
// Fiber log strain stress assertion macros
// Shared assertion helpers for the fiber log strain stress block.
// ----------------------------------------------------------------------------
`ifndef FIBER_LOG_STRAIN_STRESS_DEFINES_SVH
`define FIBER_LOG_STRAIN_STRESS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FLSS_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fiber log strain stress assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FLSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fiber log strain stress assertion failed");

`endif

// File: rtl/core/flss_pkg.sv
// ----------------------------------------------------------------------------
// Fiber log strain stress package
// Register indexes, fixed-point constants and shared helper functions.
// ----------------------------------------------------------------------------
package flss_pkg;

  typedef enum logic [1:0] {
    CfgModulus    = 2'd0,
    CfgRefStretch = 2'd1,
    CfgThreshold  = 2'd2
  } cfg_idx_e;

  localparam int unsigned Latency   = 68;
  localparam int unsigned LogSteps  = 24;
  localparam int unsigned FracSteps = 30;

  localparam logic [31:0] OneQ24 = 32'h0100_0000;
  localparam logic [30:0] Ln2Q31 = 31'd1488522236;
  localparam logic [61:0] CapC   = {62{1'b1}};
  localparam logic [46:0] Max47  = {47{1'b1}};

  localparam int unsigned PairI [6] = '{0, 1, 2, 0, 1, 0};
  localparam int unsigned PairJ [6] = '{0, 1, 2, 1, 2, 2};

  function automatic logic [5:0] lead_one(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 64; k++) begin
      if (x[k]) begin
        p = 6'(k);
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/flss_log2.sv
// ----------------------------------------------------------------------------
// Fiber log strain stress log2 pipeline
// Base-two logarithm in Q.24: leading-one normalization, then one squaring
// of the Q1.31 mantissa per stage for each fraction bit.
// ----------------------------------------------------------------------------
module flss_log2 (
  input  logic        clk_i,
  input  logic [63:0] x_i,
  output logic [29:0] log_o
);

  localparam int unsigned Depth = flss_pkg::LogSteps + 1;

  logic [5:0]  p_q  [Depth];
  logic [31:0] y_q  [Depth];
  logic [23:0] fr_q [Depth];

  logic [5:0]  p_d;
  logic [31:0] y_d;

  always_comb begin
    p_d = flss_pkg::lead_one(x_i);
    if (p_d >= 6'd31) begin
      y_d = 32'(x_i >> (p_d - 6'd31));
    end else begin
      y_d = 32'(x_i << (6'd31 - p_d));
    end
  end

  always_ff @(posedge clk_i) begin
    p_q[0]  <= p_d;
    y_q[0]  <= y_d;
    fr_q[0] <= '0;
  end

  for (genvar g = 1; g < Depth; g++) begin : g_step
    localparam int unsigned Bit = flss_pkg::LogSteps - g;
    logic [63:0] sq;
    logic [32:0] sh;

    assign sq = 64'(y_q[g-1]) * 64'(y_q[g-1]);
    assign sh = sq[63:31];

    always_ff @(posedge clk_i) begin
      p_q[g] <= p_q[g-1];
      if (sh[32]) begin
        y_q[g]  <= sh[32:1];
        fr_q[g] <= fr_q[g-1] | (24'd1 << Bit);
      end else begin
        y_q[g]  <= sh[31:0];
        fr_q[g] <= fr_q[g-1];
      end
    end
  end

  assign log_o = {p_q[Depth-1], fr_q[Depth-1]};

endmodule

// File: rtl/core/flss_frac_div.sv
// ----------------------------------------------------------------------------
// Fiber log strain stress direction divider
// Six pipelined restoring divisions floor(p * 2^30 / s) sharing one divisor,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module flss_frac_div (
  input  logic        clk_i,
  input  logic [59:0] p_i [6],
  input  logic [61:0] s_i,
  output logic [30:0] d_o [6]
);

  localparam int unsigned Depth = flss_pkg::FracSteps + 1;

  logic [61:0] rem_q [Depth][6];
  logic [30:0] quo_q [Depth][6];
  logic [61:0] div_q [Depth];

  always_ff @(posedge clk_i) begin
    div_q[0] <= s_i;
    for (int i = 0; i < 6; i++) begin
      if ({2'd0, p_i[i]} >= s_i) begin
        rem_q[0][i] <= {2'd0, p_i[i]} - s_i;
        quo_q[0][i] <= 31'd1;
      end else begin
        rem_q[0][i] <= {2'd0, p_i[i]};
        quo_q[0][i] <= '0;
      end
    end
  end

  for (genvar g = 1; g < Depth; g++) begin : g_step
    always_ff @(posedge clk_i) begin
      div_q[g] <= div_q[g-1];
      for (int i = 0; i < 6; i++) begin
        if ({rem_q[g-1][i], 1'b0} >= {1'b0, div_q[g-1]}) begin
          rem_q[g][i] <= 62'({rem_q[g-1][i], 1'b0} - {1'b0, div_q[g-1]});
          quo_q[g][i] <= {quo_q[g-1][i][29:0], 1'b1};
        end else begin
          rem_q[g][i] <= {rem_q[g-1][i][60:0], 1'b0};
          quo_q[g][i] <= {quo_q[g-1][i][29:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      d_o[i] = quo_q[Depth-1][i];
    end
  end

endmodule

// File: rtl/core/fiber_log_strain_stress.sv
// ----------------------------------------------------------------------------
// Fiber log strain stress
// Natural-strain fiber stress and energy per integration point, fully
// pipelined with one item accepted per clock.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle: busy is always low and an
// item is taken whenever start is high. Each result appears on the output
// ports when its item leaves the pipeline, for one cycle, marked by done_o;
// the receiver cannot stall it. The latency is set by the pipeline depth,
// chiefly the 24 squaring stages of the logarithm and the 31 two-bit stages
// of the modulus-over-Jacobian division. Configuration writes take effect
// for items started after the pipeline has drained.
module fiber_log_strain_stress (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] grad_xx_i,
  input  logic [31:0] grad_xy_i,
  input  logic [31:0] grad_xz_i,
  input  logic [31:0] grad_yx_i,
  input  logic [31:0] grad_yy_i,
  input  logic [31:0] grad_yz_i,
  input  logic [31:0] grad_zx_i,
  input  logic [31:0] grad_zy_i,
  input  logic [31:0] grad_zz_i,
  input  logic [47:0] fiber_dir_i,
  input  logic [30:0] volume_ratio_i,
  output logic        done_o,
  output logic [47:0] stress_xx_o,
  output logic [47:0] stress_yy_o,
  output logic [47:0] stress_zz_o,
  output logic [47:0] stress_xy_o,
  output logic [47:0] stress_yz_o,
  output logic [47:0] stress_xz_o,
  output logic [46:0] energy_density_o,
  output logic        in_tension_o
);

  `include "fiber_log_strain_stress_defines.svh"

  localparam int unsigned Lat = flss_pkg::Latency;

  logic [31:0] mod_q, lam_q;
  logic [23:0] thr_q;
  logic [31:0] lam_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
      lam_q <= flss_pkg::OneQ24;
      thr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        flss_pkg::CfgModulus:    mod_q <= cfg_wdata_i;
        flss_pkg::CfgRefStretch: lam_q <= cfg_wdata_i;
        flss_pkg::CfgThreshold:  thr_q <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign lam_eff = (lam_q < flss_pkg::OneQ24) ? flss_pkg::OneQ24 : lam_q;
  assign busy    = 1'b0;

  logic [Lat-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  // Stage 1: fiber vector F*n0.
  logic signed [31:0] f [9];
  logic signed [15:0] nd [3];
  logic signed [47:0] pr [9];
  logic signed [49:0] n1_d [3];
  logic signed [49:0] n1_q [3];
  logic [30:0] j1_q;

  assign f[0] = grad_xx_i;
  assign f[1] = grad_xy_i;
  assign f[2] = grad_xz_i;
  assign f[3] = grad_yx_i;
  assign f[4] = grad_yy_i;
  assign f[5] = grad_yz_i;
  assign f[6] = grad_zx_i;
  assign f[7] = grad_zy_i;
  assign f[8] = grad_zz_i;
  assign nd[0] = fiber_dir_i[15:0];
  assign nd[1] = fiber_dir_i[31:16];
  assign nd[2] = fiber_dir_i[47:32];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pr[k] = f[k] * nd[k % 3];
    end
    for (int i = 0; i < 3; i++) begin
      n1_d[i] = 50'(pr[3*i]) + 50'(pr[3*i+1]) + 50'(pr[3*i+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d;
    j1_q <= (volume_ratio_i == '0) ? 31'd1 : volume_ratio_i;
  end

  // Stage 2: magnitudes, signs and the largest magnitude.
  logic [47:0] mag2_d [3];
  logic [47:0] mag2_q [3];
  logic [2:0]  neg2_q;
  logic [47:0] mx2_d, mx2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag2_d[i] = n1_q[i][49] ? 48'(-n1_q[i]) : n1_q[i][47:0];
    end
    mx2_d = mag2_d[0];
    if (mag2_d[1] > mx2_d) mx2_d = mag2_d[1];
    if (mag2_d[2] > mx2_d) mx2_d = mag2_d[2];
  end

  always_ff @(posedge clk_i) begin
    mag2_q <= mag2_d;
    mx2_q  <= mx2_d;
    for (int i = 0; i < 3; i++) begin
      neg2_q[i] <= n1_q[i][49];
    end
  end

  // Stage 3: scale the components below 2^30.
  logic [5:0]  lp3;
  logic [4:0]  s3_d, s3_q;
  logic [29:0] a3_q [3];
  logic        nz3_q;

  assign lp3  = flss_pkg::lead_one({16'd0, mx2_q});
  assign s3_d = (mx2_q[47:30] != '0) ? 5'(lp3 - 6'd29) : 5'd0;

  always_ff @(posedge clk_i) begin
    s3_q  <= s3_d;
    nz3_q <= (mx2_q != '0);
    for (int i = 0; i < 3; i++) begin
      a3_q[i] <= 30'(mag2_q[i] >> s3_d);
    end
  end

  // Stage 4: pair products. Stage 5: squared length.
  logic [59:0] pp4_q [6];
  logic [59:0] pp5_q [6];
  logic [61:0] ss5_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      pp4_q[k] <= 60'(a3_q[flss_pkg::PairI[k]]) * 60'(a3_q[flss_pkg::PairJ[k]]);
    end
    pp5_q <= pp4_q;
    ss5_q <= 62'(pp4_q[0]) + 62'(pp4_q[1]) + 62'(pp4_q[2]);
  end

  logic [29:0] lgs, lgl;
  logic [30:0] d36 [6];

  flss_log2 u_log_len (
    .clk_i (clk_i),
    .x_i   ({2'd0, ss5_q}),
    .log_o (lgs)
  );

  flss_log2 u_log_ref (
    .clk_i (clk_i),
    .x_i   ({32'd0, lam_eff}),
    .log_o (lgl)
  );

  flss_frac_div u_dir_div (
    .clk_i (clk_i),
    .p_i   (pp5_q),
    .s_i   (ss5_q),
    .d_o   (d36)
  );

  // Side delay lines.
  logic [30:0] j_dl_q   [64];
  logic [4:0]  s_dl_q   [27];
  logic [2:0]  neg_dl_q [65];
  logic        nz_dl_q  [29];

  always_ff @(posedge clk_i) begin
    j_dl_q[0]   <= j1_q;
    s_dl_q[0]   <= s3_q;
    neg_dl_q[0] <= neg2_q;
    nz_dl_q[0]  <= nz3_q;
    for (int k = 1; k < 64; k++) j_dl_q[k] <= j_dl_q[k-1];
    for (int k = 1; k < 27; k++) s_dl_q[k] <= s_dl_q[k-1];
    for (int k = 1; k < 65; k++) neg_dl_q[k] <= neg_dl_q[k-1];
    for (int k = 1; k < 29; k++) nz_dl_q[k] <= nz_dl_q[k-1];
  end

  // Stages 31 to 33: natural strain.
  logic signed [33:0] v31_d, v31_q;
  logic [30:0] vm;
  logic        vn32_q;
  logic [61:0] pr32_q;
  logic [62:0] rnd33;
  logic [30:0] em33_q;
  logic        ten33_q;

  assign v31_d = $signed({4'd0, lgs})
               + (($signed({29'd0, s_dl_q[26]}) - 34'sd14) <<< 25)
               - $signed({3'd0, lgl, 1'b0});
  assign vm    = v31_q[33] ? 31'(-v31_q) : v31_q[30:0];
  assign rnd33 = 63'(pr32_q) + 63'h8000_0000;

  always_ff @(posedge clk_i) begin
    v31_q   <= v31_d;
    vn32_q  <= v31_q[33];
    pr32_q  <= 62'(vm) * 62'(flss_pkg::Ln2Q31);
    em33_q  <= rnd33[62:32];
    ten33_q <= nz_dl_q[28] & ~vn32_q & (rnd33[62:32] > {7'd0, thr_q});
  end

  // Stages 34 to 37: scale product and energy.
  logic [62:0] t34_q;
  logic [61:0] emsq34_q;
  logic [61:0] rnd35;
  logic [37:0] e2_35_q;
  logic [50:0] ml36_q, mh36_q;
  logic [63:0] sum37;
  logic [46:0] en37_q;

  assign rnd35 = emsq34_q + 62'h80_0000;
  assign sum37 = 64'({mh36_q, 19'd0}) + 64'(ml36_q) + 64'd65536;

  always_ff @(posedge clk_i) begin
    t34_q    <= 63'(mod_q) * 63'(em33_q);
    emsq34_q <= 62'(em33_q) * 62'(em33_q);
    e2_35_q  <= rnd35[61:24];
    ml36_q   <= 51'(mod_q) * 51'(e2_35_q[18:0]);
    mh36_q   <= 51'(mod_q) * 51'(e2_35_q[37:19]);
    en37_q   <= sum37[63:17];
  end

  // Stages 35 to 66: c = modulus * strain * 2^8 / J, two quotient bits a stage.
  logic [30:0] dr_q  [32];
  logic [61:0] dn_q  [32];
  logic [61:0] dq_q  [32];
  logic        dov_q [32];
  logic        ov35;

  assign ov35 = ({22'd0, t34_q[62:54]} >= j_dl_q[32]);

  always_ff @(posedge clk_i) begin
    dov_q[0] <= ov35;
    dr_q[0]  <= ov35 ? 31'd0 : {22'd0, t34_q[62:54]};
    dn_q[0]  <= {t34_q[53:0], 8'd0};
    dq_q[0]  <= '0;
  end

  for (genvar g = 1; g < 32; g++) begin : g_cdiv
    logic [30:0] r;
    logic [31:0] r2;
    logic [61:0] nb, q;

    always_comb begin
      r  = dr_q[g-1];
      nb = dn_q[g-1];
      q  = dq_q[g-1];
      r2 = '0;
      for (int b = 0; b < 2; b++) begin
        r2 = {r, nb[61]};
        nb = {nb[60:0], 1'b0};
        if (r2 >= {1'b0, j_dl_q[32+g]}) begin
          r = 31'(r2 - {1'b0, j_dl_q[32+g]});
          q = {q[60:0], 1'b1};
        end else begin
          r = r2[30:0];
          q = {q[60:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dov_q[g] <= dov_q[g-1];
      dr_q[g]  <= r;
      dn_q[g]  <= nb;
      dq_q[g]  <= q;
    end
  end

  logic [30:0] d_dl_q   [30][6];
  logic [46:0] en_dl_q  [30];
  logic        ten_dl_q [34];

  always_ff @(posedge clk_i) begin
    d_dl_q[0]   <= d36;
    en_dl_q[0]  <= en37_q;
    ten_dl_q[0] <= ten33_q;
    for (int k = 1; k < 30; k++) begin
      d_dl_q[k]  <= d_dl_q[k-1];
      en_dl_q[k] <= en_dl_q[k-1];
    end
    for (int k = 1; k < 34; k++) ten_dl_q[k] <= ten_dl_q[k-1];
  end

  // Stage 67: split products. Stage 68: round, saturate, sign and mask.
  logic [61:0] c66;
  logic [61:0] hp67_q [6];
  logic [61:0] lp67_q [6];
  logic [47:0] str_d [6];
  logic [47:0] str_q [6];
  logic [46:0] en_q;
  logic        ten_q;

  assign c66 = dov_q[31] ? flss_pkg::CapC : dq_q[31];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      hp67_q[k] <= 62'(c66[61:31]) * 62'(d_dl_q[29][k]);
      lp67_q[k] <= 62'(c66[30:0]) * 62'(d_dl_q[29][k]);
    end
  end

  always_comb begin
    logic [62:0] lr;
    logic [63:0] m;
    logic [46:0] ms;
    for (int k = 0; k < 6; k++) begin
      lr = 63'(lp67_q[k]) + 63'h2000_0000;
      m  = 64'({hp67_q[k], 1'b0}) + 64'(lr[62:30]);
      ms = (m > 64'(flss_pkg::Max47)) ? flss_pkg::Max47 : m[46:0];
      if (!ten_dl_q[33]) begin
        str_d[k] = '0;
      end else if (neg_dl_q[64][flss_pkg::PairI[k]] ^ neg_dl_q[64][flss_pkg::PairJ[k]]) begin
        str_d[k] = 48'(-{1'b0, ms});
      end else begin
        str_d[k] = {1'b0, ms};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    str_q <= str_d;
    en_q  <= ten_dl_q[33] ? en_dl_q[29] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ten_q <= 1'b0;
    end else begin
      ten_q <= ten_dl_q[33] & vld_q[Lat-2];
    end
  end

  assign done_o           = vld_q[Lat-1];
  assign stress_xx_o      = str_q[0];
  assign stress_yy_o      = str_q[1];
  assign stress_zz_o      = str_q[2];
  assign stress_xy_o      = str_q[3];
  assign stress_yz_o      = str_q[4];
  assign stress_xz_o      = str_q[5];
  assign energy_density_o = en_q;
  assign in_tension_o     = ten_q;

  `FLSS_ASSERT(a_tension_has_done, in_tension_o, done_o)
  `FLSS_ASSERT(a_idle_zero, done_o && !in_tension_o, (energy_density_o == '0) && (stress_xx_o == '0) && (stress_xy_o == '0))
  `FLSS_ASSERT(a_diag_nonneg, in_tension_o, !stress_xx_o[47] && !stress_yy_o[47] && !stress_zz_o[47])
  `FLSS_ASSERT(a_latency, start, ##(flss_pkg::Latency) done_o)

endmodule

// File: tb/sv/tb_fiber_log_strain_stress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fiber log strain stress testbench
// Drives a table of directed items and then random items through several
// register settings, predicts every result in fixed point and compares each
// result field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fiber_log_strain_stress;

  localparam int unsigned CycleLimit = 600000;
  localparam logic [63:0] Ln2Const   = 64'd1488522236;
  localparam logic [63:0] Max47Const = 64'd140737488355327;
  localparam logic [63:0] CapConst   = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] OneConst   = 32'h0100_0000;

  typedef struct {
    logic [31:0] grad [9];
    logic [47:0] dir;
    logic [30:0] vol;
    bit          known_zero;
  } point_t;

  typedef struct {
    logic [47:0] stress [6];
    logic [46:0] energy;
    logic        tension;
  } stress_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;
  logic        start;
  logic        busy;
  logic [31:0] grad_i [9];
  logic [47:0] fiber_dir_i;
  logic [30:0] volume_ratio_i;
  logic        done_o;
  logic [47:0] stress_o [6];
  logic [46:0] energy_density_o;
  logic        in_tension_o;

  logic [31:0] modulus_q;
  logic [31:0] ref_stretch_q;
  logic [23:0] threshold_q;

  stress_res_t expected_q [$];
  bit          failed;
  int unsigned cycles;
  bit          in_known;
  point_t      rows [$];

  fiber_log_strain_stress DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .grad_xx_i(grad_i[0]), .grad_xy_i(grad_i[1]), .grad_xz_i(grad_i[2]),
    .grad_yx_i(grad_i[3]), .grad_yy_i(grad_i[4]), .grad_yz_i(grad_i[5]),
    .grad_zx_i(grad_i[6]), .grad_zy_i(grad_i[7]), .grad_zz_i(grad_i[8]),
    .fiber_dir_i, .volume_ratio_i, .done_o,
    .stress_xx_o(stress_o[0]), .stress_yy_o(stress_o[1]), .stress_zz_o(stress_o[2]),
    .stress_xy_o(stress_o[3]), .stress_yz_o(stress_o[4]), .stress_xz_o(stress_o[5]),
    .energy_density_o, .in_tension_o
  );

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic logic [63:0] log2_fix(logic [63:0] x);
    int p;
    logic [63:0] y, fr;
    p = 63;
    fr = '0;
    while (p > 0 && !x[p]) p--;
    y = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
    for (int k = 23; k >= 0; k--) begin
      y = (y * y) >> 31;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        fr[k] = 1'b1;
      end
    end
    return (64'(p) << 24) | fr;
  endfunction

  function automatic logic [63:0] share_q30(logic [63:0] p, logic [63:0] s);
    logic [63:0] q, rem;
    q = '0;
    rem = p;
    if (rem >= s) begin
      rem -= s;
      q = 64'd1;
    end
    for (int k = 0; k < 30; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= s) begin
        rem -= s;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic stress_res_t fiber_stress(point_t pt);
    stress_res_t res;
    int pi [6] = '{0, 1, 2, 0, 1, 0};
    int pj [6] = '{0, 1, 2, 1, 2, 2};
    longint n, v, eps;
    logic [63:0] mag [3], a [3];
    bit neg [3];
    logic [63:0] mx, ssum, jac, lam0, vm, em, t, q, r, c, d, ch, cl, m, e2, en;
    int s;
    for (int i = 0; i < 6; i++) res.stress[i] = '0;
    res.energy = '0;
    res.tension = 1'b0;
    jac = (pt.vol == 0) ? 64'd1 : 64'(pt.vol);
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      n = 0;
      for (int k = 0; k < 3; k++)
        n += longint'($signed(pt.grad[3 * i + k])) * longint'($signed(pt.dir[16 * k +: 16]));
      neg[i] = n < 0;
      mag[i] = n < 0 ? 64'(-n) : 64'(n);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return res;
    s = 0;
    while ((mx >> s) >= 64'h4000_0000) s++;
    for (int i = 0; i < 3; i++) a[i] = mag[i] >> s;
    ssum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    lam0 = (ref_stretch_q < OneConst) ? 64'(OneConst) : 64'(ref_stretch_q);
    v = longint'(log2_fix(ssum)) + longint'(s - 14) * 64'sd33554432
        - 2 * longint'(log2_fix(lam0));
    vm = v < 0 ? 64'(-v) : 64'(v);
    em = (vm * Ln2Const + 64'h8000_0000) >> 32;
    eps = v < 0 ? -longint'(em) : longint'(em);
    if (eps <= longint'(threshold_q)) return res;
    t = 64'(modulus_q) * em;
    q = t / jac;
    r = t % jac;
    if (q >= (64'd1 << 54)) c = CapConst;
    else begin
      c = (q << 8) + ((r << 8) / jac);
      if (c > CapConst) c = CapConst;
    end
    ch = c >> 31;
    cl = c & 64'h7FFF_FFFF;
    for (int i = 0; i < 6; i++) begin
      d = share_q30(a[pi[i]] * a[pj[i]], ssum);
      m = ch * d * 2 + ((cl * d + 64'h2000_0000) >> 30);
      if (m > Max47Const) m = Max47Const;
      res.stress[i] = (neg[pi[i]] ^ neg[pj[i]]) ? 48'(-m) : 48'(m);
    end
    e2 = (em * em + 64'h80_0000) >> 24;
    en = (64'(modulus_q) * e2 + 64'h1_0000) >> 17;
    if (en > Max47Const) en = Max47Const;
    res.energy = en[46:0];
    res.tension = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      point_t pt;
      stress_res_t zr;
      for (int i = 0; i < 9; i++) pt.grad[i] = grad_i[i];
      pt.dir = fiber_dir_i;
      pt.vol = volume_ratio_i;
      if (in_known) begin
        for (int i = 0; i < 6; i++) zr.stress[i] = '0;
        zr.energy = '0;
        zr.tension = 1'b0;
        expected_q.push_back(zr);
      end else begin
        expected_q.push_back(fiber_stress(pt));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("fiber_log_strain_stress: mismatch");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual tension %0b", $time, in_tension_o);
        failed = 1'b1;
      end else begin
        stress_res_t ex;
        ex = expected_q.pop_front();
        for (int i = 0; i < 6; i++)
          if (stress_o[i] !== ex.stress[i]) begin
            $display("%0t: stress %0d expected %h actual %h", $time, i, ex.stress[i],
                     stress_o[i]);
            failed = 1'b1;
          end
        if (energy_density_o !== ex.energy) begin
          $display("%0t: energy expected %h actual %h", $time, ex.energy,
                   energy_density_o);
          failed = 1'b1;
        end
        if (in_tension_o !== ex.tension) begin
          $display("%0t: tension expected %b actual %b", $time, ex.tension, in_tension_o);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic write_reg(flss_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      flss_pkg::CfgModulus:    modulus_q     = val;
      flss_pkg::CfgRefStretch: ref_stretch_q = val;
      flss_pkg::CfgThreshold:  threshold_q   = val[23:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (flss_pkg::Latency + 8) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int r, len;
    r = $urandom_range(0, 99);
    len = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  task automatic send_point(point_t pt);
    idle_gap();
    for (int i = 0; i < 9; i++) grad_i[i] <= pt.grad[i];
    fiber_dir_i    <= pt.dir;
    volume_ratio_i <= pt.vol;
    in_known       <= pt.known_zero;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic point_t rand_point();
    point_t pt;
    int mode, sc;
    mode = $urandom_range(0, 9);
    sc = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) begin
      if (mode < 2) pt.grad[i] = $urandom;
      else begin
        pt.grad[i] = ((i % 4) == 0) ? (OneConst << sc) + $urandom_range(0, 32'h00FF_FFFF) : 0;
        pt.grad[i] = pt.grad[i] + ($signed($urandom_range(0, 32'h0FF_FFFF)) >>> 2)
                     - 32'h001F_FFFF;
      end
    end
    if ($urandom_range(0, 3) == 0) pt.dir = 48'({$urandom, $urandom});
    else begin
      pt.dir = '0;
      pt.dir[16 * $urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
      pt.dir[16 * $urandom_range(0, 2) +: 16] = 16'($urandom);
    end
    case ($urandom_range(0, 7))
      0:       pt.vol = 31'($urandom);
      1:       pt.vol = 31'($urandom_range(0, 3));
      default: pt.vol = 31'(OneConst + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
    endcase
    pt.known_zero = 1'b0;
    return pt;
  endfunction

  function automatic point_t make_row(logic [31:0] diag, logic [31:0] off, logic [47:0] dir,
                                      logic [30:0] vol, bit known);
    point_t pt;
    for (int i = 0; i < 9; i++) pt.grad[i] = ((i % 4) == 0) ? diag : off;
    pt.dir = dir;
    pt.vol = vol;
    pt.known_zero = known;
    return pt;
  endfunction

  logic [31:0] mod_set [6] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0123_4567,
                               32'h8000_0000, 32'h0000_0000};
  logic [31:0] ref_set [6] = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0180_0000,
                               32'h00FF_FFFF, 32'h0100_0000};
  logic [23:0] thr_set [6] = '{24'h00_0000, 24'hFF_FFFF, 24'h00_0000, 24'h10_0000,
                               24'h00_0001, 24'h00_0000};

  initial begin
    failed = 1'b0;
    cycles = 0;
    in_known = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = flss_pkg::CfgModulus;
    cfg_wdata_i = '0;
    start = 1'b0;
    for (int i = 0; i < 9; i++) grad_i[i] = '0;
    fiber_dir_i = '0;
    volume_ratio_i = '0;
    modulus_q = '0;
    ref_stretch_q = OneConst;
    threshold_q = '0;

    rows.push_back(make_row(32'h0, 32'h0, 48'h0000_0000_4000, 31'h0100_0000, 1'b1));
    rows.push_back(make_row(OneConst, 32'h0, 48'h0, 31'h0100_0000, 1'b1));
    rows.push_back(make_row(OneConst, 32'h0, 48'h0000_0000_4000, 31'h0100_0000, 1'b1));
    rows.push_back(make_row(OneConst, 32'h0, 48'h4000_0000_0000, 31'h0100_0000, 1'b1));
    rows.push_back(make_row(32'h0200_0000, 32'h0, 48'h0000_0000_4000, 31'h0100_0000, 1'b0));
    rows.push_back(make_row(32'h0200_0000, 32'h0080_0000, 48'h2D41_2D41_2D41, 31'h0, 1'b0));
    rows.push_back(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_7FFF_7FFF, 31'h7FFF_FFFF,
                            1'b0));
    rows.push_back(make_row(32'h8000_0000, 32'h8000_0000, 48'h8000_8000_8000, 31'h1, 1'b0));
    rows.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 31'h1, 1'b0));
    rows.push_back(make_row(32'h0300_0000, 32'hFF00_0000, 48'hC000_4000_C000, 31'h0040_0000,
                            1'b0));
    rows.push_back(make_row(32'h0100_0001, 32'h0, 48'h0000_4000_0000, 31'h0100_0000, 1'b0));
    rows.push_back(make_row(32'hFFFF_FFFF, 32'h0000_0001, 48'h0001_0001_0001, 31'h7FFF_FFFF,
                            1'b0));
    rows.push_back(make_row(32'h7FFF_FFFF, 32'h0, 48'h4000_0000_0000, 31'h0, 1'b0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(flss_pkg::CfgModulus, mod_set[ph - 1]);
        write_reg(flss_pkg::CfgRefStretch, ref_set[ph - 1]);
        write_reg(flss_pkg::CfgThreshold, {8'h0, thr_set[ph - 1]});
        if (ph == 3) write_reg(flss_pkg::cfg_idx_e'(2'd3), 32'hFFFF_FFFF);
      end
      if (ph < 2) foreach (rows[k]) send_point(rows[k]);
      for (int k = 0; k < 180; k++) send_point(rand_point());
    end
    in_known <= 1'b0;
    drain();

    if (!failed && expected_q.size() == 0) begin
      $display("fiber_log_strain_stress: match");
    end else begin
      $display("fiber_log_strain_stress: mismatch");
    end
    $finish;
  end

endmodule
